[sv/cclr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the checked command line receiver.
// Has no dependencies. The line core and the top level both use it.
package cclr_pkg;

  // Verdict codes given at the end of a line or when a line overflows.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_OK       = 3'd1,
    EV_FORCED   = 3'd2,
    EV_REJECTED = 3'd3,
    EV_NO_CHECK = 3'd4,
    EV_EMPTY    = 3'd5,
    EV_OVERLONG = 3'd6
  } line_event_e;

  // Character constants.
  localparam logic [6:0] CHAR_LF    = 7'd10;
  localparam logic [6:0] CHAR_CR    = 7'd13;
  localparam logic [6:0] CHAR_SPACE = 7'd32;
  localparam logic [6:0] CHAR_SEMI  = 7'd59;
  localparam logic [7:0] BYTE_MIN   = 8'd10;
  localparam logic [7:0] BYTE_LIMIT = 8'h80;

  // Check arithmetic constants.
  localparam logic signed [10:0] DIGIT_ZERO = 11'sd48;
  localparam logic signed [10:0] DIGIT_BASE = 11'sd10;
  localparam logic [7:0]         CHECK_MOD  = 8'd99;
  localparam logic [7:0]         CHECK_MOD2 = 8'd198;

  // One result word as it leaves the line core.
  typedef struct packed {
    logic        echo_valid;
    logic [6:0]  out_byte;
    logic        stored;
    logic [5:0]  position;
    line_event_e line_event;
    logic        prompt;
    logic [5:0]  line_length;
  } result_t;

endpackage

[sv/cclr_line_core.sv]
`timescale 1ns / 1ps
// Line state and single-pass step logic of the command line receiver.
// Depends on cclr_pkg for the result struct and the character constants.
module cclr_line_core #(
  parameter int LINE_MAX = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [6:0]              byte_i,
  input  logic signed [2:0]       echo_mode_i,
  output cclr_pkg::result_t       result_o
);
  import cclr_pkg::*;

  localparam int CW = $clog2(LINE_MAX);
  localparam int XW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] CNT_LAST = CW'(LINE_MAX - 1);

  logic [CW-1:0] count_q, count_d;
  logic [6:0]    first_q, first_d;
  logic [6:0]    tens_q, tens_d;
  logic [6:0]    units_q, units_d;
  logic [6:0]    sum_q, sum_d;

  logic                is_print;
  logic                is_eol;
  logic [7:0]          sum_raw;
  logic [7:0]          sum_red;
  logic signed [10:0]  tens_s;
  logic signed [10:0]  units_s;
  logic signed [10:0]  check_s;
  logic signed [10:0]  target_s;
  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       len_x;
  line_event_e         event_d;

  // Running sum of the body characters, reduced modulo 99 by compare and subtract.
  always_comb begin
    sum_raw = {1'b0, sum_q} + {1'b0, byte_i};
    if (sum_raw >= CHECK_MOD2) begin
      sum_red = sum_raw - CHECK_MOD2;
    end else if (sum_raw >= CHECK_MOD) begin
      sum_red = sum_raw - CHECK_MOD;
    end else begin
      sum_red = sum_raw;
    end
  end

  // Decoded check value against the running sum plus one.
  always_comb begin
    tens_s   = $signed({4'b0, tens_q}) - DIGIT_ZERO;
    units_s  = $signed({4'b0, units_q}) - DIGIT_ZERO;
    check_s  = 11'(tens_s * DIGIT_BASE + units_s);
    target_s = $signed({4'b0, sum_q}) + 11'sd1;
  end

  // Next line state and the result word for the current byte.
  always_comb begin
    is_print = (byte_i >= CHAR_SPACE);
    is_eol   = (byte_i == CHAR_LF) || (byte_i == CHAR_CR);

    count_d = count_q;
    first_d = first_q;
    tens_d  = tens_q;
    units_d = units_q;
    sum_d   = sum_q;
    event_d = EV_NONE;
    pos_x   = '0;
    len_x   = '0;

    // Store a printable character at the next position.
    if (is_print) begin
      pos_x = XW'(count_q);
      priority if (count_q == CW'(0)) begin
        first_d = byte_i;
      end else if (count_q == CW'(1)) begin
        tens_d = byte_i;
      end else if (count_q == CW'(2)) begin
        units_d = byte_i;
      end else begin
        sum_d = sum_red[6:0];
      end
      if (count_q < CNT_LAST) begin
        count_d = count_q + CW'(1);
      end
    end

    // Verdict at a line end, or discard when the line is full.
    if (is_eol) begin
      len_x = XW'(count_d);
      if (count_d == '0) begin
        event_d = EV_EMPTY;
      end else if (first_q == CHAR_SEMI) begin
        if (check_s == target_s) begin
          event_d = EV_OK;
        end else if (echo_mode_i != 3'sd0) begin
          event_d = EV_FORCED;
        end else begin
          event_d = EV_REJECTED;
        end
      end else begin
        event_d = EV_NO_CHECK;
      end
    end else if (count_d >= CNT_LAST) begin
      event_d = EV_OVERLONG;
    end

    if (event_d != EV_NONE) begin
      count_d = '0;
      first_d = '0;
      tens_d  = '0;
      units_d = '0;
      sum_d   = '0;
    end

    result_o.echo_valid  = (echo_mode_i != 3'sd0);
    result_o.out_byte    = byte_i;
    result_o.stored      = is_print;
    result_o.position    = pos_x[5:0];
    result_o.line_event  = event_d;
    result_o.prompt      = is_eol && (echo_mode_i == 3'sd1);
    result_o.line_length = len_x[5:0];
  end

  // Line state registers, updated once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= '0;
      tens_q  <= '0;
      units_q <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      first_q <= first_d;
      tens_q  <= tens_d;
      units_q <= units_d;
      sum_q   <= sum_d;
    end
  end

endmodule

[sv/checked_command_line_receiver_unit.sv]
`timescale 1ns / 1ps
// Top level of the checked command line receiver: input register, echo mode
// register, result register. Depends on cclr_pkg and cclr_line_core.
//
//   Channel  | Handshake               | Word
//   ---------+-------------------------+------------------------------------
//   rx       | rx_valid_i / rx_ready_o | rx_byte_i
//   cfg      | cfg_valid_i/cfg_ready_o | cfg_data_i (echo mode)
//   out      | out_valid_o/out_ready_i | echo_valid_o .. line_length_o
//
// One byte per cycle while the result is taken: a word enters the input
// register, then passes the line core straight into the result register.
// Bytes outside 10..127 leave the input register without a result.
// Reset clears the line state and sets the echo mode to zero.
// A stalled result holds the result register; the input register still
// drains bytes that give no result, and otherwise waits for the result slot.
module checked_command_line_receiver_unit #(
  parameter int LINE_MAX = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic signed [2:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              echo_valid_o,
  output logic [6:0]        out_byte_o,
  output logic              stored_o,
  output logic [5:0]        position_o,
  output logic [2:0]        line_event_o,
  output logic              prompt_o,
  output logic [5:0]        line_length_o
);
  import cclr_pkg::*;

  logic              in_vld_q, in_vld_d;
  logic [7:0]        in_byte_q;
  logic signed [2:0] echo_q;
  logic              out_vld_q, out_vld_d;
  result_t           res_q;
  result_t           res_d;
  logic              keep;
  logic              advance;
  logic              step;

  // Only bytes 10..127 are processed.
  assign keep    = (in_byte_q >= BYTE_MIN) && (in_byte_q < BYTE_LIMIT);
  assign advance = in_vld_q && (!keep || !out_vld_q || out_ready_i);
  assign step    = advance && keep;

  assign rx_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  cclr_line_core #(
    .LINE_MAX(LINE_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q[6:0]),
    .echo_mode_i (echo_q),
    .result_o    (res_d)
  );

  // Valid flags of the input and result registers.
  always_comb begin
    in_vld_d = in_vld_q;
    if (rx_ready_o) begin
      in_vld_d = rx_valid_i;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      echo_q    <= 3'sd0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        echo_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign echo_valid_o  = res_q.echo_valid;
  assign out_byte_o    = res_q.out_byte;
  assign stored_o      = res_q.stored;
  assign position_o    = res_q.position;
  assign line_event_o  = res_q.line_event;
  assign prompt_o      = res_q.prompt;
  assign line_length_o = res_q.line_length;

  // A stored character is never a line end, so it carries no length or prompt.
  a_stored_no_eol : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stored_o |-> (line_length_o == 6'd0) && !prompt_o)
    else $error("stored character carries line end fields");

  // A prompt is only requested while echo is on.
  a_prompt_echo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prompt_o |-> echo_valid_o)
    else $error("prompt without echo");

  // Unstored bytes report position zero.
  a_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stored_o |-> position_o == 6'd0)
    else $error("position given for an unstored byte");

  // A byte outside the processed range never reaches the result register.
  a_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !keep && out_vld_q && !out_ready_i |=> out_vld_q && $stable(res_q))
    else $error("ignored byte disturbed the result register");

endmodule
